>>> src/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared definitions for the degree-input sine/cosine pipeline
// Formats, turn constants, the operation codes and the arctangent table.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int ANGLE_W = 24;
    localparam int OP_W    = 2;
    localparam int VALUE_W = 16;

    // Default number of rotation stages; the valid range is 8 to 32.
    localparam int ROTATION_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES        = 32;

    // Angle reduction: 360 degrees with 8 fraction bits is 45 * 2^11.
    localparam int LOW_W    = 11;
    localparam int QUO_W    = ANGLE_W - LOW_W;
    localparam int T_W      = QUO_W + 1;
    localparam int REM_W    = 6;
    localparam int TURN_W   = REM_W + LOW_W;
    localparam int QQ_W     = 8;
    localparam int RECIP_W  = 15;
    localparam int PROD_W   = T_W + RECIP_W;
    localparam int RECIP_SH = 20;

    localparam logic [T_W-1:0]     MOD_OFFSET = T_W'(44);
    localparam logic [RECIP_W-1:0] RECIP_45   = RECIP_W'(23302);
    localparam logic [T_W-1:0]     TURN_DIV   = T_W'(45);

    localparam logic [TURN_W-1:0] QUARTER_TURN   = TURN_W'(23040);
    localparam logic [TURN_W-1:0] THREE_QUARTERS = TURN_W'(69120);
    localparam int                RS_W           = TURN_W + 1;
    localparam logic [RS_W-1:0]   HALF_TURN      = RS_W'(46080);
    localparam logic [RS_W-1:0]   FULL_TURN      = RS_W'(92160);

    // Rotation datapath: x and y with 30 fraction bits, z in degrees with 20.
    localparam int XY_W     = 33;
    localparam int Z_W      = 32;
    localparam int Z_SHIFT  = 12;
    localparam int ROUND_SH = 16;
    localparam int SH_W     = XY_W - ROUND_SH;

    typedef logic signed [XY_W-1:0]    t_xy;
    typedef logic signed [Z_W-1:0]     t_z;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [SH_W-1:0]    t_sh;

    localparam t_xy    GAIN_Q30   = t_xy'(652032874);
    localparam t_xy    ROUND_HALF = t_xy'(32768);
    localparam t_z     Z_FOLD_MAX = t_z'(94371840);
    localparam t_value ONE_Q14    = t_value'(16384);
    localparam t_sh    ONE_SH     = t_sh'(16384);

    typedef enum logic [OP_W-1:0] {
        OP_COS       = 2'd0,
        OP_SIN       = 2'd1,
        OP_NEG_SIN   = 2'd2,
        OP_COS_DERIV = 2'd3
    } t_op;

    // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest.
    localparam t_z ATAN_DEG_Q20 [0:ATAN_ENTRIES-1] = '{
        t_z'(47185920), t_z'(27855475), t_z'(14718068), t_z'(7471121),
        t_z'(3750058),  t_z'(1876857),  t_z'(938658),   t_z'(469357),
        t_z'(234682),   t_z'(117342),   t_z'(58671),    t_z'(29335),
        t_z'(14668),    t_z'(7334),     t_z'(3667),     t_z'(1833),
        t_z'(917),      t_z'(458),      t_z'(229),      t_z'(115),
        t_z'(57),       t_z'(29),       t_z'(14),       t_z'(7),
        t_z'(4),        t_z'(2),        t_z'(1),        t_z'(0),
        t_z'(0),        t_z'(0),        t_z'(0),        t_z'(0)
    };

endpackage

>>> src/scd_if.sv
// ----------------------------------------------------------------------------
// scd_if: channel interfaces for the sine/cosine pipeline
// Valid/ready channels for the angle requests and the trigonometric results.
// ----------------------------------------------------------------------------
interface scd_in_if;
    logic                           valid;
    logic                           ready;
    logic [scd_pkg::ANGLE_W-1:0]    angle_deg;
    logic [scd_pkg::OP_W-1:0]       operation;

    modport source (output valid, output angle_deg, output operation, input ready);
    modport sink   (input valid, input angle_deg, input operation, output ready);
endinterface

interface scd_out_if;
    logic                           valid;
    logic                           ready;
    logic [scd_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> src/sine_cosine_of_degrees_top.sv
// ----------------------------------------------------------------------------
// sine_cosine_of_degrees_top: pipelined CORDIC sine/cosine of an angle in degrees
// One transaction is accepted every cycle unless backpressure fills the stages; the rotation stages are unrolled.
// Each stage holds its item under backpressure and takes a new one when free.
// Synchronous reset clears only the stage valid bits; the datapath is not reset.
// ----------------------------------------------------------------------------
module sine_cosine_of_degrees_top #(
    parameter int ROTATION_STAGES = scd_pkg::ROTATION_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scd_in_if.sink      i_in,
    scd_out_if.source   o_out
);

    localparam int NS     = ROTATION_STAGES;
    localparam int P      = NS + 4;
    localparam int FOLD_K = 2;
    localparam int ROT_K  = 3;

    // Stage valid bits and per-stage load enables.
    logic [P-1:0] r_vld;
    logic [P-1:0] n_vld;
    logic [P:0]   en;

    // Stage 0: reciprocal multiply for the turn count.
    logic [scd_pkg::T_W-1:0]    s0_t;
    logic [scd_pkg::PROD_W-1:0] s0_prod;
    logic [scd_pkg::T_W-1:0]    r_s0_t;
    logic [scd_pkg::QQ_W-1:0]   r_s0_qq;
    logic [scd_pkg::LOW_W-1:0]  r_s0_lo;
    scd_pkg::t_op               r_s0_op;

    // Stage 1: remainder and reduced angle in [0, 360) degrees.
    logic [scd_pkg::T_W-1:0]    s1_rem;
    logic [scd_pkg::TURN_W-1:0] r_s1_r;
    scd_pkg::t_op               r_s1_op;

    // Stage 2: quadrant fold.
    logic signed [scd_pkg::RS_W-1:0] s2_rs;
    logic                            s2_neg;

    // Rotation registers; index 0 is the output of the fold stage.
    scd_pkg::t_xy r_x   [0:NS];
    scd_pkg::t_xy r_y   [0:NS];
    scd_pkg::t_z  r_z   [0:NS];
    logic         r_neg [0:NS];
    scd_pkg::t_op r_op  [0:NS];
    scd_pkg::t_xy n_x   [1:NS];
    scd_pkg::t_xy n_y   [1:NS];
    scd_pkg::t_z  n_z   [1:NS];

    // Output stage.
    scd_pkg::t_xy    x_rnd;
    scd_pkg::t_xy    y_rnd;
    scd_pkg::t_value c_sat;
    scd_pkg::t_value s_sat;
    scd_pkg::t_value n_value;
    scd_pkg::t_value r_value;

    logic in_acc;
    logic out_acc;

    function automatic scd_pkg::t_value sat_q14(input scd_pkg::t_sh v);
        scd_pkg::t_value res;
        if (v > scd_pkg::ONE_SH) begin
            res = scd_pkg::ONE_Q14;
        end else if (v < -scd_pkg::ONE_SH) begin
            res = -scd_pkg::ONE_Q14;
        end else begin
            res = v[scd_pkg::VALUE_W-1:0];
        end
        return res;
    endfunction

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        en[P] = o_out.ready;
        for (int k = P - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld      = {r_vld[P-2:0], i_in.valid};
    assign i_in.ready = en[0];
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < P; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // The angle is q * 2048 + lo with q signed; q + 4096 + 44 is congruent to
    // q modulo 45, and the reciprocal multiply gives its exact quotient by 45.
    always_comb begin
        s0_t    = scd_pkg::T_W'({~i_in.angle_deg[scd_pkg::ANGLE_W-1],
                                 i_in.angle_deg[scd_pkg::ANGLE_W-2:scd_pkg::LOW_W]})
                  + scd_pkg::MOD_OFFSET;
        s0_prod = scd_pkg::PROD_W'(s0_t) * scd_pkg::PROD_W'(scd_pkg::RECIP_45);
    end

    assign s1_rem = r_s0_t - scd_pkg::T_W'(r_s0_qq) * scd_pkg::TURN_DIV;

    // Fold the second and third quadrants onto the first and fourth; angles above 270 wrap to negative.
    always_comb begin
        s2_neg = 1'b0;
        s2_rs  = scd_pkg::RS_W'(r_s1_r);
        if (r_s1_r > scd_pkg::QUARTER_TURN && r_s1_r <= scd_pkg::THREE_QUARTERS) begin
            s2_rs  = scd_pkg::RS_W'(r_s1_r) - scd_pkg::HALF_TURN;
            s2_neg = 1'b1;
        end else if (r_s1_r > scd_pkg::THREE_QUARTERS) begin
            s2_rs  = scd_pkg::RS_W'(r_s1_r) - scd_pkg::FULL_TURN;
        end
    end

    // One micro-rotation per stage, steered by the sign of the residual angle.
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            if (!r_z[i][scd_pkg::Z_W-1]) begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - scd_pkg::ATAN_DEG_Q20[i];
            end else begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + scd_pkg::ATAN_DEG_Q20[i];
            end
        end
    end

    // Round to 14 fraction bits, saturate, then apply the fold sign and the operation.
    always_comb begin
        x_rnd = r_x[NS] + scd_pkg::ROUND_HALF;
        y_rnd = r_y[NS] + scd_pkg::ROUND_HALF;
        c_sat = sat_q14(x_rnd[scd_pkg::XY_W-1:scd_pkg::ROUND_SH]);
        s_sat = sat_q14(y_rnd[scd_pkg::XY_W-1:scd_pkg::ROUND_SH]);
        if (r_neg[NS]) begin
            c_sat = -c_sat;
            s_sat = -s_sat;
        end
        case (r_op[NS])
            scd_pkg::OP_COS:       n_value = c_sat;
            scd_pkg::OP_SIN:       n_value = s_sat;
            scd_pkg::OP_NEG_SIN:   n_value = -s_sat;
            scd_pkg::OP_COS_DERIV: n_value = c_sat;
            default:               n_value = c_sat;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_t  <= s0_t;
            r_s0_qq <= s0_prod[scd_pkg::RECIP_SH +: scd_pkg::QQ_W];
            r_s0_lo <= i_in.angle_deg[scd_pkg::LOW_W-1:0];
            r_s0_op <= scd_pkg::t_op'(i_in.operation);
        end
        if (en[1]) begin
            r_s1_r  <= {s1_rem[scd_pkg::REM_W-1:0], r_s0_lo};
            r_s1_op <= r_s0_op;
        end
        if (en[FOLD_K]) begin
            r_x[0]   <= scd_pkg::GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= scd_pkg::t_z'(s2_rs) <<< scd_pkg::Z_SHIFT;
            r_neg[0] <= s2_neg;
            r_op[0]  <= r_s1_op;
        end
        for (int i = 0; i < NS; i++) begin
            if (en[ROT_K+i]) begin
                r_x[i+1]   <= n_x[i+1];
                r_y[i+1]   <= n_y[i+1];
                r_z[i+1]   <= n_z[i+1];
                r_neg[i+1] <= r_neg[i];
                r_op[i+1]  <= r_op[i];
            end
        end
        if (en[P-1]) begin
            r_value <= n_value;
        end
    end

    assign o_out.valid = r_vld[P-1];
    assign o_out.value = r_value;

`ifndef SYNTHESIS
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.value) <= scd_pkg::ONE_Q14 &&
                         $signed(o_out.value) >= -scd_pkg::ONE_Q14))
        else $error("result outside the unit range");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[FOLD_K] |-> (r_z[0] <= scd_pkg::Z_FOLD_MAX && r_z[0] >= -scd_pkg::Z_FOLD_MAX))
        else $error("folded angle outside +/-90 degrees");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[P-1] || o_out.ready) |-> i_in.ready)
        else $error("input stalled although the output stage can move");

    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_vld) ==
                 $past($countones(r_vld)) + int'($past(in_acc)) - int'($past(out_acc)))
        else $error("transaction lost or duplicated in the pipeline");
`endif

endmodule
